// ----- sv/xbt_pkg.sv -----
// ----------------------------------------------------------------------------
// XML block tokenizer package
// Shared types, byte codes and sizes for the byte-serial XML block lexer.
// ----------------------------------------------------------------------------
package xbt_pkg;

  // Default width of the internal byte offset counter.
  localparam int OFFSET_WIDTH_DEF = 32;
  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Width of one byte.
  localparam int BYTE_W = 8;

  // Byte codes the lexer looks at.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_X      = 8'h78;

  // Kind of a reported block.
  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_COMMENT = 3'd1,
    KIND_PROLOG  = 3'd2,
    KIND_OPEN    = 3'd3,
    KIND_CLOSE   = 3'd4,
    KIND_EMPTY   = 3'd5,
    KIND_END     = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_t;

  // Scanner phase of the back part.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TEXT    = 3'd1,
    PH_LT      = 3'd2,
    PH_TAG     = 3'd3,
    PH_COMMENT = 3'd4,
    PH_PROLOG  = 3'd5,
    PH_DROP    = 3'd6
  } phase_t;

  // Category of a block that opened with '<'.
  typedef enum logic [2:0] {
    CAT_NONE    = 3'd0,
    CAT_COMMENT = 3'd1,
    CAT_PROLOG  = 3'd2,
    CAT_OPEN    = 3'd3,
    CAT_CLOSE   = 3'd4
  } cat_t;

  // Byte classification made by the front part.
  typedef struct packed {
    logic       is_zero;
    logic       is_lt;
    logic       is_gt;
    logic       is_space;
    logic       is_quote;
    logic [1:0] extra;     // UTF-8 continuation bytes announced by a lead byte
  } byte_class_t;

  localparam int CLASS_W = $bits(byte_class_t);

endpackage

// ----- sv/xbt_front.sv -----
// ----------------------------------------------------------------------------
// XML block tokenizer front part
// Accepts document bytes, tags each with its offset and classifies it.
// ----------------------------------------------------------------------------
module xbt_front #(
  parameter int OFFSET_WIDTH = xbt_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Byte stream in.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // doc_byte
  // Queue write side.
  input  logic                          q_ready,
  output logic                          q_push,
  output logic [7:0]                    q_byte,
  output xbt_pkg::byte_class_t          q_class,
  output logic [OFFSET_WIDTH-1:0]       q_offset
);

  logic [OFFSET_WIDTH-1:0] byte_offset;
  logic [OFFSET_WIDTH-1:0] byte_offset_next;
  logic [7:0]              b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid && q_ready;
  assign q_byte        = b;
  assign q_offset      = byte_offset;

  // Classify the byte for the scanner.
  always_comb begin
    q_class.is_zero  = (b == xbt_pkg::CH_NUL);
    q_class.is_lt    = (b == xbt_pkg::CH_LT);
    q_class.is_gt    = (b == xbt_pkg::CH_GT);
    q_class.is_space = (b == xbt_pkg::CH_SPACE) || (b == xbt_pkg::CH_TAB) ||
                       (b == xbt_pkg::CH_LF) || (b == xbt_pkg::CH_VT) ||
                       (b == xbt_pkg::CH_FF) || (b == xbt_pkg::CH_CR);
    q_class.is_quote = (b == xbt_pkg::CH_SQUOTE) || (b == xbt_pkg::CH_DQUOTE);
    if (b[7:5] == 3'b110) begin
      q_class.extra = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      q_class.extra = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      q_class.extra = 2'd3;
    end else begin
      q_class.extra = 2'd0;
    end
  end

  // Offset counter saturates and restarts after the document end.
  always_comb begin
    if (b == xbt_pkg::CH_NUL) begin
      byte_offset_next = '0;
    end else if (&byte_offset) begin
      byte_offset_next = byte_offset;
    end else begin
      byte_offset_next = byte_offset + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
    end else if (q_push) begin
      byte_offset <= byte_offset_next;
    end
  end

endmodule

// ----- sv/xbt_queue.sv -----
// ----------------------------------------------------------------------------
// XML block tokenizer queue
// Short register queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
module xbt_queue #(
  parameter int DATA_W      = 8,
  parameter int QUEUE_DEPTH = xbt_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] rd_data,
  output logic [CNT_W-1:0]  count
);

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign ready   = (count != CNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/xbt_back.sv -----
// ----------------------------------------------------------------------------
// XML block tokenizer back part
// Runs the block scanner over classified bytes and registers each result.
// ----------------------------------------------------------------------------
module xbt_back #(
  parameter int OFFSET_WIDTH = xbt_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // Queue read side.
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [7:0]              q_byte,
  input  xbt_pkg::byte_class_t    q_class,
  input  logic [OFFSET_WIDTH-1:0] q_offset,
  // Block stream out.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [63:0]             m_axis_tdata,   // start_offset, end_offset
  output logic [2:0]              m_axis_tuser    // block_kind
);

  // Scanner state.
  xbt_pkg::phase_t         scan_phase, scan_phase_next;
  logic [2:0]              tag_position, tag_position_next;
  xbt_pkg::cat_t           tag_category, tag_category_next;
  logic                    in_literal, in_literal_next;
  logic [7:0]              literal_mark, literal_mark_next;
  logic [15:0]             recent_bytes, recent_bytes_next;
  logic [1:0]              continuation_left, continuation_left_next;
  logic [OFFSET_WIDTH-1:0] block_start, block_start_next;

  // Output register.
  logic                    out_valid;
  xbt_pkg::kind_t          out_kind;
  logic [31:0]             out_start;
  logic [31:0]             out_end;

  // Shared decode.
  logic [7:0]              b;
  logic [7:0]              prev;
  logic [7:0]              prev2;
  logic [2:0]              pos_n;
  logic                    live;
  logic                    tag_keep;
  xbt_pkg::cat_t           cat_lt;
  xbt_pkg::cat_t           cat_body;
  logic                    body_on;
  logic                    body_end;
  xbt_pkg::kind_t          body_kind;
  logic                    emit;
  xbt_pkg::kind_t          emit_kind;
  logic [OFFSET_WIDTH-1:0] emit_start;
  logic [OFFSET_WIDTH-1:0] emit_end;

  assign b     = q_byte;
  assign prev  = recent_bytes[7:0];
  assign prev2 = recent_bytes[15:8];
  assign pos_n = (tag_position != 3'd7) ? tag_position + 3'd1 : 3'd7;
  assign q_pop = q_valid && (!out_valid || m_axis_tready);

  // A byte that the scanner examines: not the end, not dropped, not skipped.
  assign live = !q_class.is_zero && (scan_phase != xbt_pkg::PH_DROP) &&
                (continuation_left == 2'd0);

  // Category picked by the byte after '<'.
  always_comb begin
    if (b == xbt_pkg::CH_BANG) begin
      cat_lt = xbt_pkg::CAT_COMMENT;
    end else if (b == xbt_pkg::CH_QMARK) begin
      cat_lt = xbt_pkg::CAT_PROLOG;
    end else if (b == xbt_pkg::CH_SLASH) begin
      cat_lt = xbt_pkg::CAT_CLOSE;
    end else begin
      cat_lt = xbt_pkg::CAT_OPEN;
    end
  end

  // The comment or prolog prefix is still being matched.
  assign tag_keep =
    ((tag_category == xbt_pkg::CAT_COMMENT) &&
     ((pos_n == 3'd2) || (pos_n == 3'd3)) && (b == xbt_pkg::CH_DASH)) ||
    ((tag_category == xbt_pkg::CAT_PROLOG) &&
     (((pos_n == 3'd2) && (b == xbt_pkg::CH_X)) ||
      ((pos_n == 3'd3) && (b == xbt_pkg::CH_M)) ||
      ((pos_n == 3'd4) && (b == xbt_pkg::CH_L))));

  // Category in force for a tag or prolog body byte; a broken prefix is an open tag.
  always_comb begin
    if (scan_phase == xbt_pkg::PH_LT) begin
      cat_body = cat_lt;
    end else if ((scan_phase == xbt_pkg::PH_TAG) &&
                 ((tag_category == xbt_pkg::CAT_COMMENT) ||
                  (tag_category == xbt_pkg::CAT_PROLOG))) begin
      cat_body = xbt_pkg::CAT_OPEN;
    end else begin
      cat_body = tag_category;
    end
  end

  assign body_on = live &&
    (((scan_phase == xbt_pkg::PH_LT) && !q_class.is_space) ||
     ((scan_phase == xbt_pkg::PH_TAG) && !tag_keep) ||
     (scan_phase == xbt_pkg::PH_PROLOG));

  // A '>' outside a literal closes the tag; a prolog also needs '?' before it.
  assign body_end = body_on && !in_literal && !q_class.is_quote && q_class.is_gt &&
                    ((scan_phase != xbt_pkg::PH_PROLOG) || (prev == xbt_pkg::CH_QMARK));

  always_comb begin
    case (cat_body)
      xbt_pkg::CAT_COMMENT: body_kind = xbt_pkg::KIND_COMMENT;
      xbt_pkg::CAT_PROLOG:  body_kind = xbt_pkg::KIND_PROLOG;
      xbt_pkg::CAT_CLOSE:   body_kind = xbt_pkg::KIND_CLOSE;
      xbt_pkg::CAT_OPEN: begin
        body_kind = (prev == xbt_pkg::CH_SLASH) ? xbt_pkg::KIND_EMPTY : xbt_pkg::KIND_OPEN;
      end
      default:              body_kind = xbt_pkg::KIND_TEXT;
    endcase
  end

  // Result of the byte at the queue head.
  always_comb begin
    emit       = 1'b0;
    emit_kind  = xbt_pkg::KIND_ERROR;
    emit_start = block_start;
    emit_end   = q_offset;
    if (q_class.is_zero) begin
      if ((scan_phase == xbt_pkg::PH_IDLE) || (scan_phase == xbt_pkg::PH_TEXT)) begin
        emit       = 1'b1;
        emit_kind  = xbt_pkg::KIND_END;
        emit_start = q_offset;
      end else if (scan_phase != xbt_pkg::PH_DROP) begin
        emit = 1'b1;
      end
    end else if (live) begin
      if ((scan_phase == xbt_pkg::PH_TEXT) && q_class.is_lt) begin
        emit      = 1'b1;
        emit_kind = xbt_pkg::KIND_TEXT;
        emit_end  = (q_offset > block_start) ? q_offset - 1'b1 : q_offset;
      end else if ((scan_phase == xbt_pkg::PH_LT) && q_class.is_space) begin
        emit = 1'b1;
      end else if ((scan_phase == xbt_pkg::PH_COMMENT) && q_class.is_gt &&
                   (prev == xbt_pkg::CH_DASH) && (prev2 == xbt_pkg::CH_DASH)) begin
        emit      = 1'b1;
        emit_kind = xbt_pkg::KIND_COMMENT;
      end else if (body_end) begin
        emit      = 1'b1;
        emit_kind = body_kind;
      end
    end
  end

  // Next scanner state.
  always_comb begin
    scan_phase_next        = scan_phase;
    tag_position_next      = tag_position;
    tag_category_next      = tag_category;
    in_literal_next        = in_literal;
    literal_mark_next      = literal_mark;
    recent_bytes_next      = recent_bytes;
    continuation_left_next = continuation_left;
    block_start_next       = block_start;
    if (q_class.is_zero) begin
      scan_phase_next        = xbt_pkg::PH_IDLE;
      tag_position_next      = '0;
      tag_category_next      = xbt_pkg::CAT_NONE;
      in_literal_next        = 1'b0;
      literal_mark_next      = '0;
      recent_bytes_next      = '0;
      continuation_left_next = '0;
      block_start_next       = '0;
    end else if (scan_phase != xbt_pkg::PH_DROP) begin
      tag_position_next = pos_n;
      if (continuation_left != 2'd0) begin
        // Skipped continuation byte: held as zero in the byte history.
        continuation_left_next = continuation_left - 2'd1;
        recent_bytes_next      = {recent_bytes[7:0], 8'h00};
      end else begin
        recent_bytes_next      = {recent_bytes[7:0], b};
        continuation_left_next = q_class.extra;
        case (scan_phase)
          xbt_pkg::PH_IDLE: begin
            block_start_next = q_offset;
            if (q_class.is_lt) begin
              scan_phase_next   = xbt_pkg::PH_LT;
              tag_position_next = '0;
              tag_category_next = xbt_pkg::CAT_NONE;
              in_literal_next   = 1'b0;
            end else begin
              scan_phase_next = xbt_pkg::PH_TEXT;
            end
          end
          xbt_pkg::PH_TEXT: begin
            if (q_class.is_lt) begin
              scan_phase_next   = xbt_pkg::PH_LT;
              block_start_next  = q_offset;
              tag_position_next = '0;
              tag_category_next = xbt_pkg::CAT_NONE;
              in_literal_next   = 1'b0;
            end
          end
          xbt_pkg::PH_LT: begin
            if (q_class.is_space) begin
              scan_phase_next = xbt_pkg::PH_DROP;
            end else begin
              scan_phase_next   = xbt_pkg::PH_TAG;
              tag_category_next = cat_lt;
            end
          end
          xbt_pkg::PH_TAG: begin
            if (tag_keep) begin
              if ((tag_category == xbt_pkg::CAT_COMMENT) && (pos_n == 3'd3)) begin
                scan_phase_next   = xbt_pkg::PH_COMMENT;
                recent_bytes_next = '0;
              end else if ((tag_category == xbt_pkg::CAT_PROLOG) && (pos_n == 3'd4)) begin
                scan_phase_next   = xbt_pkg::PH_PROLOG;
                recent_bytes_next = '0;
                in_literal_next   = 1'b0;
              end
            end else begin
              tag_category_next = cat_body;
            end
          end
          xbt_pkg::PH_PROLOG: begin
          end
          xbt_pkg::PH_COMMENT: begin
            if (emit) begin
              scan_phase_next = xbt_pkg::PH_IDLE;
            end
          end
          default: begin
            scan_phase_next = xbt_pkg::PH_DROP;
          end
        endcase
        // Literal tracking and tag close for tag and prolog bodies.
        if (body_on) begin
          if (in_literal) begin
            if (b == literal_mark) begin
              in_literal_next = 1'b0;
            end
          end else if (q_class.is_quote) begin
            in_literal_next   = 1'b1;
            literal_mark_next = b;
          end else if (body_end) begin
            scan_phase_next = xbt_pkg::PH_IDLE;
          end
        end
      end
    end
  end

  // Scanner registers advance on each byte taken from the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase        <= xbt_pkg::PH_IDLE;
      tag_position      <= '0;
      tag_category      <= xbt_pkg::CAT_NONE;
      in_literal        <= 1'b0;
      literal_mark      <= '0;
      recent_bytes      <= '0;
      continuation_left <= '0;
      block_start       <= '0;
    end else if (q_pop) begin
      scan_phase        <= scan_phase_next;
      tag_position      <= tag_position_next;
      tag_category      <= tag_category_next;
      in_literal        <= in_literal_next;
      literal_mark      <= literal_mark_next;
      recent_bytes      <= recent_bytes_next;
      continuation_left <= continuation_left_next;
      block_start       <= block_start_next;
    end
  end

  // Output register holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_kind  <= emit_kind;
      out_start <= 32'(emit_start);
      out_end   <= 32'(emit_end);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_end, out_start};
  assign m_axis_tuser  = out_kind;

endmodule

// ----- sv/xml_block_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// XML block tokenizer
// Byte-serial XML lexer that reports text, comment, prolog and tag blocks, and end-of-document and error results.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] doc_byte
//  m_axis    out        tuser[2:0] block_kind; tdata[31:0] start_offset,
//                       tdata[63:32] end_offset
//
// One byte is taken per cycle while the queue has room. A byte is written into the
// queue on its input transfer, and its result is registered in the output register
// when the back part pops it from the queue.
// The scanner step in the back part sets the rate at one byte per cycle.
// While a result waits on m_axis_tready the back part stops, and the queue takes
// up to QUEUE_DEPTH bytes before s_axis_tready drops. Reset clears the scanner,
// queue and offset counter.
module xml_block_tokenizer_top #(
  parameter int OFFSET_WIDTH = xbt_pkg::OFFSET_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = xbt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // doc_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // start_offset, end_offset
  output logic [2:0]  m_axis_tuser    // block_kind
);

  localparam int DATA_W = xbt_pkg::BYTE_W + xbt_pkg::CLASS_W + OFFSET_WIDTH;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  logic                    q_ready;
  logic                    q_push;
  logic [7:0]              f_byte;
  xbt_pkg::byte_class_t    f_class;
  logic [OFFSET_WIDTH-1:0] f_offset;
  logic                    q_valid;
  logic                    q_pop;
  logic [DATA_W-1:0]       q_rd_data;
  logic [CNT_W-1:0]        q_count;
  logic [7:0]              b_byte;
  xbt_pkg::byte_class_t    b_class;
  logic [OFFSET_WIDTH-1:0] b_offset;

  // Front: offset and byte class.
  xbt_front #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_byte        (f_byte),
    .q_class       (f_class),
    .q_offset      (f_offset)
  );

  // Queue between the two parts.
  xbt_queue #(
    .DATA_W      (DATA_W),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data ({f_offset, f_class, f_byte}),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data),
    .count   (q_count)
  );

  assign {b_offset, b_class, b_byte} = q_rd_data;

  // Back: block scanner and output register.
  xbt_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_byte        (b_byte),
    .q_class       (b_class),
    .q_offset      (b_offset),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // The back part only reads a queue that has an entry.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("pop from empty queue");

  // An end-of-document result starts and ends at the zero byte.
  a_end_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == 3'(xbt_pkg::KIND_END))) |->
      (m_axis_tdata[31:0] == m_axis_tdata[63:32]))
    else $error("end-of-document offsets differ");

  // Offsets of a result never run backward when they fit the port.
  a_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (OFFSET_WIDTH <= 32)) |->
      (m_axis_tdata[31:0] <= m_axis_tdata[63:32]))
    else $error("block end before block start");
`endif

endmodule
